### rtl/core/wfrd_pkg.sv
package wfrd_pkg;

    localparam int MAX_MACHINES = 16;
    localparam int IDX_W        = $clog2(MAX_MACHINES);
    localparam int CAP_W        = 31;
    localparam int CNT_W        = 16;
    localparam int MC_W         = 5;
    localparam int OUT_W        = 5;

    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    localparam logic signed [OUT_W-1:0] REJECT_CODE = -5'sd1;

    typedef struct packed {
        logic [CAP_W-1:0] cap;
        logic [CNT_W-1:0] cnt;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

endpackage

### rtl/core/worst_fit_request_dispatcher_unit.sv
// Load: written into the table at the transfer, no result; busy stays low.
// Dispatch: reads the active entries of the machine table, one per cycle, where the active
// count is the configured machine count capped at 16; then DRAIN and COMMIT. A dispatch with
// no machines gives its reject result in the cycle after the transfer and keeps busy low.
// The result strobe is high for one cycle; the receiver cannot stall it.
// Reset is asynchronous, active low, and empties the table through per-entry valid bits.
module worst_fit_request_dispatcher_unit
    import wfrd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    req_type,
    input  logic [IDX_W-1:0]        machine_index,
    input  logic [CAP_W-1:0]        amount,
    output logic                    result_valid,
    output logic signed [OUT_W-1:0] assigned_machine,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [MC_W-1:0]         cfg_data
);

    state_t                   state_reg, state_next;
    logic [MC_W-1:0]          mc_reg;
    logic [MC_W-1:0]          active_cnt;
    logic [MC_W-1:0]          n_reg, n_next;
    logic [IDX_W-1:0]         addr_reg, addr_next;
    logic [CAP_W-1:0]         amt_reg, amt_next;
    logic                     res_vld_reg, res_vld_next;
    logic signed [OUT_W-1:0]  res_reg, res_next;
    logic [MAX_MACHINES-1:0]  valid_reg;

    // Table memory and its registered read port.
    entry_t                   mem [MAX_MACHINES];
    entry_t                   rd_data_reg;
    logic                     rd_ok_reg;
    logic                     rd_vld_reg;
    logic [IDX_W-1:0]         rd_idx_reg;

    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    entry_t                   wr_data;

    entry_t                   rd_entry;
    logic                     better;
    entry_t                   best_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic                     fit;

    assign cfg_ready        = 1'b1;
    assign busy             = (state_reg != ST_IDLE);
    assign result_valid     = res_vld_reg;
    assign assigned_machine = res_reg;

    assign active_cnt = (mc_reg > MC_W'(MAX_MACHINES)) ? MC_W'(MAX_MACHINES) : mc_reg;

    // Entries never loaded since reset read as zero capacity and zero count.
    assign rd_entry = rd_ok_reg ? rd_data_reg : '0;
    assign better   = (rd_entry.cap > best_reg.cap) ||
                      ((rd_entry.cap == best_reg.cap) && (rd_entry.cnt < best_reg.cnt));
    assign fit      = (amt_reg <= best_reg.cap);

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        addr_next    = addr_reg;
        amt_next     = amt_reg;
        res_vld_next = 1'b0;
        res_next     = res_reg;
        wr_en        = 1'b0;
        wr_addr      = machine_index;
        wr_data      = {amount, CNT_W'(0)};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    amt_next = amount;
                    if (req_type == REQ_LOAD)
                    begin
                        wr_en = 1'b1;
                    end
                    else if (active_cnt == '0)
                    begin
                        res_vld_next = 1'b1;
                        res_next     = REJECT_CODE;
                    end
                    else
                    begin
                        n_next     = active_cnt;
                        addr_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                addr_next = addr_reg + 1'b1;
                if ({1'b0, addr_reg} == n_reg - 1'b1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                res_vld_next = 1'b1;
                state_next   = ST_IDLE;
                if (fit)
                begin
                    wr_en       = 1'b1;
                    wr_addr     = best_idx_reg;
                    wr_data.cap = best_reg.cap - amt_reg;
                    wr_data.cnt = (best_reg.cnt == '1) ? best_reg.cnt
                                                       : best_reg.cnt + 1'b1;
                    res_next    = $signed({1'b0, best_idx_reg});
                end
                else
                begin
                    res_next = REJECT_CODE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mc_reg      <= '0;
            res_vld_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            valid_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            res_vld_reg <= res_vld_next;
            rd_vld_reg  <= (state_reg == ST_SCAN);
            if (cfg_valid && cfg_ready)
            begin
                mc_reg <= cfg_data;
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        addr_reg   <= addr_next;
        amt_reg    <= amt_next;
        res_reg    <= res_next;
        rd_idx_reg <= addr_reg;
        rd_ok_reg  <= valid_reg[addr_reg];
        // The first entry of a scan seeds the running best; later ones replace it
        // only when strictly better, so ties keep the lower index.
        if (rd_vld_reg && ((rd_idx_reg == '0) || better))
        begin
            best_reg     <= rd_entry;
            best_idx_reg <= rd_idx_reg;
        end
    end

    // The read port reads every cycle, but the reads a scan uses never meet its write-back,
    // since the write-back ends the scan and the next item starts after it.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[addr_reg];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

### rtl/core/wfrd_checker.sv
module wfrd_checker
    import wfrd_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    req_type,
    input logic                    result_valid,
    input logic signed [OUT_W-1:0] assigned_machine
);

    // A load transfer never produces a result.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req_type == REQ_LOAD) |=> !result_valid)
        else $error("result after a load transfer");

    // The scan only begins on a dispatch transfer.
    a_busy_from_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (req_type == REQ_DISPATCH)))
        else $error("busy rose without a dispatch transfer");

    // The end of a scan always delivers its result.
    a_scan_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("scan ended without a result");

    // A machine can only be assigned after a scan.
    a_assign_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (assigned_machine != REJECT_CODE) |-> $past(busy))
        else $error("machine assigned without a scan");

endmodule

bind worst_fit_request_dispatcher_unit wfrd_checker u_wfrd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .req_type         (req_type),
    .result_valid     (result_valid),
    .assigned_machine (assigned_machine)
);

### test/worst_fit_request_dispatcher_unit_tb.sv
`timescale 1ns / 100ps

module worst_fit_request_dispatcher_unit_tb;
    import wfrd_pkg::*;

    localparam logic [CNT_W-1:0] CNT_SAT    = '1;
    localparam logic [CAP_W-1:0] CAP_TOP    = '1;
    localparam int               SAT_RUN    = 40;
    localparam int               PHASE_REQS = 175;

    typedef struct {
        logic             kind;
        logic [IDX_W-1:0] slot;
        logic [CAP_W-1:0] amt;
    } request_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    req_type;
    logic [IDX_W-1:0]        machine_index;
    logic [CAP_W-1:0]        amount;
    logic                    result_valid;
    logic signed [OUT_W-1:0] assigned_machine;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [MC_W-1:0]         cfg_data;

    request_t                pending_reqs[$];
    request_t                cur_req;
    logic signed [OUT_W-1:0] expected_machine_q[$];
    logic signed [OUT_W-1:0] want_machine;
    logic [CAP_W-1:0]        shadow_cap [MAX_MACHINES];
    logic [CNT_W-1:0]        shadow_cnt [MAX_MACHINES];
    logic [MC_W-1:0]         shadow_machine_count;
    int                      mismatch_count;
    int                      gap_left;
    int                      calm_left;
    bit                      taken;
    bit                      no_gaps;

    worst_fit_request_dispatcher_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .req_type         (req_type),
        .machine_index    (machine_index),
        .amount           (amount),
        .result_valid     (result_valid),
        .assigned_machine (assigned_machine),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Worst-fit choice over the active entries: largest capacity, then fewest
    // placements, then lowest index. Loads reset an entry; a rejected request leaves the table alone.
    task automatic predict_placement(input request_t r);
        int n;
        int best;
        if (r.kind == REQ_LOAD)
        begin
            shadow_cap[r.slot] = r.amt;
            shadow_cnt[r.slot] = '0;
            return;
        end
        n = (shadow_machine_count > MAX_MACHINES) ? MAX_MACHINES : shadow_machine_count;
        if (n == 0)
        begin
            expected_machine_q.push_back(REJECT_CODE);
            return;
        end
        best = 0;
        for (int i = 1; i < n; i++)
        begin
            if (shadow_cap[i] != shadow_cap[best])
            begin
                if (shadow_cap[i] > shadow_cap[best])
                    best = i;
            end
            else if (shadow_cnt[i] < shadow_cnt[best])
                best = i;
        end
        if (r.amt > shadow_cap[best])
            expected_machine_q.push_back(REJECT_CODE);
        else
        begin
            shadow_cap[best] = shadow_cap[best] - r.amt;
            if (shadow_cnt[best] != CNT_SAT)
                shadow_cnt[best] = shadow_cnt[best] + 1'b1;
            expected_machine_q.push_back(OUT_W'(best));
        end
    endtask

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $time, what);
    endtask

    function automatic int pick_gap();
        int roll;
        if (no_gaps)
            return 0;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 3)
        begin
            calm_left = $urandom_range(60, 20);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(15, 4);
        return $urandom_range(80, 20);
    endfunction

    function automatic logic [CAP_W-1:0] pick_capacity();
        case ($urandom_range(4))
            0:       return CAP_W'($urandom_range(3));
            1:       return CAP_W'(100);
            2:       return CAP_W'($urandom);
            3:       return CAP_TOP - CAP_W'($urandom_range(3));
            default: return CAP_W'($urandom_range(1000));
        endcase
    endfunction

    function automatic logic [CAP_W-1:0] pick_request();
        case ($urandom_range(4))
            0:       return CAP_W'($urandom_range(2));
            1:       return CAP_W'($urandom_range(150));
            2:       return CAP_W'($urandom);
            3:       return CAP_TOP - CAP_W'($urandom_range(1));
            default: return CAP_W'($urandom_range(20, 1));
        endcase
    endfunction

    task automatic queue_req(input logic kind, input int slot, input logic [CAP_W-1:0] amt);
        request_t r;
        r.kind = kind;
        r.slot = IDX_W'(slot);
        r.amt  = amt;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_random(input int count);
        request_t r;
        int       live;
        live = (shadow_machine_count > MAX_MACHINES) ? MAX_MACHINES : shadow_machine_count;
        for (int k = 0; k < count; k++)
        begin
            r.kind = ($urandom_range(99) < 40) ? REQ_LOAD : REQ_DISPATCH;
            // Loads mostly land on active entries so that dispatches see fresh capacity.
            if (live != 0 && $urandom_range(3) != 0)
                r.slot = IDX_W'($urandom_range(live - 1));
            else
                r.slot = IDX_W'($urandom_range(MAX_MACHINES - 1));
            r.amt = (r.kind == REQ_LOAD) ? pick_capacity() : pick_request();
            pending_reqs.push_back(r);
        end
    endtask

    task automatic set_machine_count(input logic [MC_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_machine_count = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // The sender holds off here until every expected result is back or reported missing.
    task automatic wait_quiet();
        int spins;
        while (pending_reqs.size() != 0 || start)
            @(posedge clk);
        spins = 0;
        while (expected_machine_q.size() != 0 && spins < 200)
        begin
            @(posedge clk);
            spins++;
        end
        if (expected_machine_q.size() != 0)
        begin
            note_mismatch($sformatf("%0d expected results never arrived",
                                    expected_machine_q.size()));
            expected_machine_q.delete();
        end
        repeat (25) @(posedge clk);
    endtask

    // Driver: a transfer happens at the rising edge with start high and busy low.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || taken)
        begin
            taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                cur_req = pending_reqs.pop_front();
                req_type      <= cur_req.kind;
                machine_index <= cur_req.slot;
                amount        <= cur_req.amt;
                start         <= 1'b1;
                gap_left = pick_gap();
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: checks results first, then records the input transfer of this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_machine_q.size() == 0)
                    note_mismatch($sformatf("unexpected result: assigned_machine %0d",
                                            assigned_machine));
                else
                begin
                    want_machine = expected_machine_q.pop_front();
                    if (assigned_machine !== want_machine)
                        note_mismatch($sformatf("assigned_machine expected %0d actual %0d",
                                                want_machine, assigned_machine));
                end
            end
            if (start && !busy)
            begin
                predict_placement(cur_req);
                taken = 1'b1;
            end
        end
    end

    initial
    begin
        logic [MC_W-1:0] phase_mc [10];
        phase_mc = '{5'd16, 5'd1, 5'd0, 5'd5, 5'd31, 5'd16, 5'd17, 5'd8, 5'd2, 5'd0};
        phase_mc[9] = MC_W'($urandom_range(31));
        start         = 1'b0;
        req_type      = REQ_LOAD;
        machine_index = '0;
        amount        = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        mismatch_count = 0;
        gap_left      = 0;
        calm_left     = 0;
        taken         = 1'b0;
        no_gaps       = 1'b0;
        shadow_machine_count = '0;
        for (int i = 0; i < MAX_MACHINES; i++)
        begin
            shadow_cap[i] = '0;
            shadow_cnt[i] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // No machines configured right after reset.
        queue_req(REQ_DISPATCH, 0, 5);
        wait_quiet();

        set_machine_count(5'd4);
        queue_req(REQ_LOAD, 0, 100);
        queue_req(REQ_LOAD, 1, 100);
        queue_req(REQ_LOAD, 2, CAP_TOP);
        queue_req(REQ_LOAD, 3, 50);
        queue_req(REQ_LOAD, 15, 7);
        queue_req(REQ_DISPATCH, 9, CAP_TOP);
        queue_req(REQ_DISPATCH, 0, 0);
        queue_req(REQ_DISPATCH, 0, 0);
        queue_req(REQ_DISPATCH, 15, 101);
        queue_req(REQ_DISPATCH, 0, 100);
        queue_req(REQ_DISPATCH, 0, 100);
        queue_req(REQ_DISPATCH, 0, 51);
        queue_req(REQ_DISPATCH, 0, 50);
        queue_req(REQ_DISPATCH, 0, 0);
        wait_quiet();

        // A count above the table size selects over all sixteen entries.
        set_machine_count(5'd31);
        queue_req(REQ_DISPATCH, 0, 7);
        queue_req(REQ_DISPATCH, 0, 1);
        queue_req(REQ_LOAD, 15, 0);
        wait_quiet();
        set_machine_count(5'd16);
        queue_req(REQ_DISPATCH, 0, 0);
        wait_quiet();

        // Pile placements onto one entry back to back, then show that a fresh
        // entry with equal capacity and fewer placements wins the tie.
        set_machine_count(5'd1);
        queue_req(REQ_LOAD, 0, 1000);
        no_gaps = 1'b1;
        for (int k = 0; k < SAT_RUN; k++)
            queue_req(REQ_DISPATCH, 0, 0);
        wait_quiet();
        set_machine_count(5'd2);
        queue_req(REQ_LOAD, 1, 1000);
        queue_req(REQ_DISPATCH, 0, 0);
        queue_req(REQ_DISPATCH, 0, 1000);
        wait_quiet();
        no_gaps = 1'b0;

        foreach (phase_mc[p])
        begin
            set_machine_count(phase_mc[p]);
            queue_random(PHASE_REQS);
            wait_quiet();
        end

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### worst_fit_request_dispatcher_unit.f
rtl/core/wfrd_pkg.sv
rtl/core/worst_fit_request_dispatcher_unit.sv
rtl/core/wfrd_checker.sv
test/worst_fit_request_dispatcher_unit_tb.sv
